// ----- rtl/i2cee_pkg.sv -----
package i2cee_pkg;

  // bus sequence phases
  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_START    = 5'd1;
  localparam logic [4:0] PH_DEVW_TX  = 5'd2;
  localparam logic [4:0] PH_DEVW_ACK = 5'd3;
  localparam logic [4:0] PH_WORD_TX  = 5'd4;
  localparam logic [4:0] PH_WORD_ACK = 5'd5;
  localparam logic [4:0] PH_DATA_TX  = 5'd6;
  localparam logic [4:0] PH_DATA_ACK = 5'd7;
  localparam logic [4:0] PH_RESTART  = 5'd8;
  localparam logic [4:0] PH_DEVR_TX  = 5'd9;
  localparam logic [4:0] PH_DEVR_ACK = 5'd10;
  localparam logic [4:0] PH_RX       = 5'd11;
  localparam logic [4:0] PH_MNACK    = 5'd12;
  localparam logic [4:0] PH_STOP     = 5'd13;

  // request codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_QUANTUM_CYCLES = 1'b1;

  localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd80;
  localparam logic [15:0] QUANTUM_CYCLES_RESET = 16'd48;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
  } result_t;

endpackage

// ----- rtl/i2cee_seq.sv -----
module i2cee_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick,
  input  logic [1:0]           func,
  input  logic [7:0]           word_address,
  input  logic [7:0]           write_data,
  input  logic                 sda_in,
  input  logic [6:0]           device_address,
  input  logic [15:0]          quantum_cycles,
  output i2cee_pkg::result_t   res
);

  logic [4:0]  phase, phase_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [1:0]  step_in_bit, step_in_bit_next;
  logic [15:0] divider_count, divider_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  held_word_address, held_word_address_next;
  logic [7:0]  held_write_data, held_write_data_next;
  logic        is_read, is_read_next;
  logic        nack_flag, nack_flag_next;
  logic        scl_out, scl_out_next;
  logic        sda_out, sda_out_next;
  logic [7:0]  last_read, last_read_next;
  logic        done;
  logic [16:0] div_sum;
  logic [15:0] limit;

  always_comb begin
    phase_next             = phase;
    bit_count_next         = bit_count;
    step_in_bit_next       = step_in_bit;
    divider_count_next     = divider_count;
    shift_byte_next        = shift_byte;
    held_word_address_next = held_word_address;
    held_write_data_next   = held_write_data;
    is_read_next           = is_read;
    nack_flag_next         = nack_flag;
    scl_out_next           = scl_out;
    sda_out_next           = sda_out;
    last_read_next         = last_read;
    done                   = 1'b0;
    limit   = (quantum_cycles == 16'd0) ? 16'd1 : quantum_cycles;
    div_sum = {1'b0, divider_count} + 17'd1;

    if (phase == i2cee_pkg::PH_IDLE) begin
      if (func == i2cee_pkg::FUNC_WRITE || func == i2cee_pkg::FUNC_READ) begin
        held_word_address_next = word_address;
        held_write_data_next   = write_data;
        is_read_next           = (func == i2cee_pkg::FUNC_READ);
        nack_flag_next         = 1'b0;
        bit_count_next         = 3'd0;
        step_in_bit_next       = 2'd0;
        divider_count_next     = 16'd0;
        phase_next             = i2cee_pkg::PH_START;
      end
    end else if (div_sum < {1'b0, limit}) begin
      divider_count_next = div_sum[15:0];
    end else begin
      divider_count_next = 16'd0;
      unique case (phase) inside
        i2cee_pkg::PH_START, i2cee_pkg::PH_RESTART: begin
          step_in_bit_next = step_in_bit + 2'd1;
          case (step_in_bit)
            2'd0: sda_out_next = 1'b1;
            2'd1: scl_out_next = 1'b1;
            2'd2: sda_out_next = 1'b0;
            default: begin
              scl_out_next = 1'b0;
              if (phase == i2cee_pkg::PH_START) begin
                shift_byte_next = {device_address, 1'b0};
                phase_next      = i2cee_pkg::PH_DEVW_TX;
              end else begin
                shift_byte_next = {device_address, 1'b1};
                phase_next      = i2cee_pkg::PH_DEVR_TX;
              end
            end
          endcase
        end
        i2cee_pkg::PH_DEVW_TX, i2cee_pkg::PH_WORD_TX, i2cee_pkg::PH_DATA_TX,
        i2cee_pkg::PH_DEVR_TX: begin
          case (step_in_bit)
            2'd0: begin
              scl_out_next     = 1'b0;
              step_in_bit_next = 2'd1;
            end
            2'd1: begin
              sda_out_next     = shift_byte[7];
              step_in_bit_next = 2'd2;
            end
            default: begin
              scl_out_next     = 1'b1;
              shift_byte_next  = {shift_byte[6:0], 1'b0};
              step_in_bit_next = 2'd0;
              bit_count_next   = bit_count + 3'd1;
              if (bit_count == 3'd7) begin
                phase_next = phase + 5'd1;
              end
            end
          endcase
        end
        i2cee_pkg::PH_DEVW_ACK, i2cee_pkg::PH_WORD_ACK, i2cee_pkg::PH_DATA_ACK,
        i2cee_pkg::PH_DEVR_ACK: begin
          step_in_bit_next = step_in_bit + 2'd1;
          case (step_in_bit)
            2'd0: scl_out_next = 1'b0;
            2'd1: sda_out_next = 1'b1;
            2'd2: scl_out_next = 1'b1;
            default: begin
              if (sda_in) begin
                nack_flag_next = 1'b1;
              end
              scl_out_next = 1'b0;
              if (phase == i2cee_pkg::PH_DEVW_ACK) begin
                shift_byte_next = held_word_address;
                phase_next      = i2cee_pkg::PH_WORD_TX;
              end else if (phase == i2cee_pkg::PH_WORD_ACK) begin
                if (is_read) begin
                  phase_next = i2cee_pkg::PH_RESTART;
                end else begin
                  shift_byte_next = held_write_data;
                  phase_next      = i2cee_pkg::PH_DATA_TX;
                end
              end else if (phase == i2cee_pkg::PH_DATA_ACK) begin
                phase_next = i2cee_pkg::PH_STOP;
              end else begin
                shift_byte_next = 8'd0;
                phase_next      = i2cee_pkg::PH_RX;
              end
            end
          endcase
        end
        i2cee_pkg::PH_RX: begin
          sda_out_next = 1'b1;
          case (step_in_bit)
            2'd0: begin
              scl_out_next     = 1'b1;
              step_in_bit_next = 2'd1;
            end
            2'd1: begin
              shift_byte_next  = {shift_byte[6:0], sda_in};
              step_in_bit_next = 2'd2;
            end
            default: begin
              scl_out_next     = 1'b0;
              step_in_bit_next = 2'd0;
              bit_count_next   = bit_count + 3'd1;
              if (bit_count == 3'd7) begin
                last_read_next = shift_byte;
                phase_next     = i2cee_pkg::PH_MNACK;
              end
            end
          endcase
        end
        i2cee_pkg::PH_MNACK: begin
          case (step_in_bit)
            2'd0: begin
              sda_out_next     = 1'b1;
              step_in_bit_next = 2'd1;
            end
            2'd1: begin
              scl_out_next     = 1'b1;
              step_in_bit_next = 2'd2;
            end
            default: begin
              scl_out_next     = 1'b0;
              step_in_bit_next = 2'd0;
              phase_next       = i2cee_pkg::PH_STOP;
            end
          endcase
        end
        i2cee_pkg::PH_STOP: begin
          case (step_in_bit)
            2'd0: begin
              sda_out_next     = 1'b0;
              step_in_bit_next = 2'd1;
            end
            2'd1: begin
              scl_out_next     = 1'b1;
              step_in_bit_next = 2'd2;
            end
            default: begin
              sda_out_next     = 1'b1;
              step_in_bit_next = 2'd0;
              phase_next       = i2cee_pkg::PH_IDLE;
              done             = 1'b1;
            end
          endcase
        end
        default: begin
          step_in_bit_next = 2'd0;
          bit_count_next   = 3'd0;
          phase_next       = i2cee_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cee_pkg::PH_IDLE;
      bit_count     <= 3'd0;
      step_in_bit   <= 2'd0;
      divider_count <= 16'd0;
      nack_flag     <= 1'b0;
      scl_out       <= 1'b0;
      sda_out       <= 1'b1;
      last_read     <= 8'd0;
    end else if (tick) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      step_in_bit   <= step_in_bit_next;
      divider_count <= divider_count_next;
      nack_flag     <= nack_flag_next;
      scl_out       <= scl_out_next;
      sda_out       <= sda_out_next;
      last_read     <= last_read_next;
    end
  end

  // payload, loaded before use
  always_ff @(posedge clk) begin
    if (tick) begin
      shift_byte        <= shift_byte_next;
      held_word_address <= held_word_address_next;
      held_write_data   <= held_write_data_next;
      is_read           <= is_read_next;
    end
  end

  always_comb begin
    res.scl_level   = scl_out_next;
    res.sda_release = sda_out_next;
    res.busy_res    = (phase_next != i2cee_pkg::PH_IDLE);
    res.done_res    = done;
    res.read_data   = last_read_next;
    res.nack_seen   = nack_flag_next;
  end

endmodule

// ----- rtl/i2c_eeprom_byte_master.sv -----
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | func, word_address, write_data, sda_in
// out     | out_valid / out_ready | scl_level, sda_release, busy_res, done_res,
//         |                       | read_data, nack_seen
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per clock unless the output stalls; its result is registered in the
// output register in the following cycle. A new request is taken while the held
// result is taken downstream, so bus-state updates run one per cycle unless stalled.
// Reset: bus idle, SCL low, SDA released, address 80, quantum of 48 requests.
// A stalled output blocks only further input; cfg writes are taken at any time.
module i2c_eeprom_byte_master (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  word_address,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_release,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data,
  output logic        nack_seen,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [6:0]          device_address;
  logic [15:0]         quantum_cycles;
  logic                in_fire;
  logic                out_fire;
  i2cee_pkg::result_t  res;
  i2cee_pkg::result_t  res_reg;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cee_pkg::DEVICE_ADDRESS_RESET;
      quantum_cycles <= i2cee_pkg::QUANTUM_CYCLES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i2cee_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        i2cee_pkg::CFG_QUANTUM_CYCLES: quantum_cycles <= cfg_data;
        default: ;
      endcase
    end
  end

  // every accepted request is one tick of the bus sequencer
  i2cee_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .tick           (in_fire),
    .func           (func),
    .word_address   (word_address),
    .write_data     (write_data),
    .sda_in         (sda_in),
    .device_address (device_address),
    .quantum_cycles (quantum_cycles),
    .res            (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_reg <= res;
    end
  end

  assign scl_level   = res_reg.scl_level;
  assign sda_release = res_reg.sda_release;
  assign busy_res    = res_reg.busy_res;
  assign done_res    = res_reg.done_res;
  assign read_data   = res_reg.read_data;
  assign nack_seen   = res_reg.nack_seen;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted request produced no result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!busy_res && sda_release && scl_level))
    else $error("stop completed with bus not released or still busy");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_reg)))
    else $error("stalled result changed");

endmodule
